/* src/lob_pkg.sv */
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and constants for the price-level book update core.
// ----------------------------------------------------------------------------
`default_nettype none
package lob_pkg;

	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef struct packed {
		logic        side;
		logic [31:0] limit_price;
		logic [31:0] quantity;
	} quote_t;

	typedef struct packed {
		logic [31:0] filled_qty;
		logic [31:0] rest_qty;
		logic        status;
		logic [31:0] best_bid_price;
		logic        best_bid_valid;
		logic [31:0] best_ask_price;
		logic        best_ask_valid;
	} result_t;

	// operation on one side's level table
	typedef struct packed {
		logic        pop;
		logic        dec;
		logic        set;
		logic [31:0] price;
		logic [31:0] qty;
	} lvl_cmd_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic match;
		logic set;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic can_match;
	} dp_stat_t;

endpackage
`default_nettype wire

/* src/limit_order_book_level_update_core.sv */
// ----------------------------------------------------------------------------
// limit_order_book_level_update_core
// Price-level book: match a quote against crossing levels, then set its level.
// ----------------------------------------------------------------------------
// Accept loads the quote; the match loop takes one crossing level a cycle,
// then the set step places the level and done is shown. One quote at a time.
// A new quote may start in the cycle that done is shown.
// Reset clears both tables and the controller; the receiver cannot stall.
`default_nettype none
module limit_order_book_level_update_core #(
	parameter int LEVEL_DEPTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire lob_pkg::quote_t  quote,
	output logic                  busy,
	output logic                  done,
	output lob_pkg::result_t      result
);

	lob_pkg::ctrl_cmd_t cmd;
	lob_pkg::dp_stat_t  stat;

	lob_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.cmd(cmd), .busy(busy), .done(done)
	);

	lob_dp #(.DEPTH(LEVEL_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .quote(quote), .cmd(cmd),
		.stat(stat), .result(result)
	);

endmodule
`default_nettype wire

/* src/lob_levels.sv */
// ----------------------------------------------------------------------------
// lob_levels
// Sorted row of price-level cells for one side. Entry 0 is the best level.
// Each cell decides its next contents from its own compare and its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none
module lob_levels #(
	parameter int DEPTH = 32,
	parameter bit ASC   = 1'b1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lob_pkg::lvl_cmd_t cmd,
	output logic [31:0]            head_price,
	output logic [31:0]            head_qty,
	output logic                   head_valid,
	output logic                   drop
);

	logic [31:0] price_q [DEPTH];
	logic [31:0] qty_q   [DEPTH];
	logic        valid_q [DEPTH];

	logic [31:0] price_d [DEPTH];
	logic [31:0] qty_d   [DEPTH];
	logic        valid_d [DEPTH];

	logic [DEPTH-1:0] better_v;
	logic [DEPTH-1:0] match_v;
	logic             hit;
	logic             full;
	logic             zero_qty;

	// compare every cell against the command price
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			better_v[i] = valid_q[i] &&
				(ASC ? (price_q[i] < cmd.price) : (price_q[i] > cmd.price));
			match_v[i]  = valid_q[i] && (price_q[i] == cmd.price);
		end
	end

	assign hit      = |match_v;
	assign full     = valid_q[DEPTH-1];
	assign zero_qty = (cmd.qty == 32'd0);
	assign drop     = !zero_qty && !hit && full && better_v[DEPTH-1];

	// next contents of each cell
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			price_d[i] = price_q[i];
			qty_d[i]   = qty_q[i];
			valid_d[i] = valid_q[i];
			if (cmd.pop || (cmd.set && hit && zero_qty && !better_v[i])) begin
				// close the gap: take the next cell
				if (i == DEPTH - 1) begin
					valid_d[i] = 1'b0;
				end else begin
					price_d[i] = price_q[i+1];
					qty_d[i]   = qty_q[i+1];
					valid_d[i] = valid_q[i+1];
				end
			end else if (cmd.dec) begin
				if (i == 0) begin
					qty_d[i] = qty_q[i] - cmd.qty;
				end
			end else if (cmd.set && hit && !zero_qty) begin
				if (match_v[i]) begin
					qty_d[i] = cmd.qty;
				end
			end else if (cmd.set && !hit && !zero_qty && !drop && !better_v[i]) begin
				// open a slot at the insert position
				if (i == 0 || better_v[(i == 0) ? 0 : i-1]) begin
					price_d[i] = cmd.price;
					qty_d[i]   = cmd.qty;
					valid_d[i] = 1'b1;
				end else begin
					price_d[i] = price_q[(i == 0) ? 0 : i-1];
					qty_d[i]   = qty_q[(i == 0) ? 0 : i-1];
					valid_d[i] = valid_q[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	// clear valid bits under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) valid_q[i] <= 1'b0;
		end else begin
			for (int i = 0; i < DEPTH; i++) valid_q[i] <= valid_d[i];
		end
	end

	// advance cell payloads
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			price_q[i] <= price_d[i];
			qty_q[i]   <= qty_d[i];
		end
	end

	assign head_price = price_q[0];
	assign head_qty   = qty_q[0];
	assign head_valid = valid_q[0];

endmodule
`default_nettype wire

/* src/lob_dp.sv */
// ----------------------------------------------------------------------------
// lob_dp
// Datapath: quote registers, remaining quantity and both level tables.
// ----------------------------------------------------------------------------
`default_nettype none
module lob_dp #(
	parameter int DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lob_pkg::quote_t    quote,
	input  wire lob_pkg::ctrl_cmd_t cmd,
	output lob_pkg::dp_stat_t       stat,
	output lob_pkg::result_t        result
);

	logic        side_q;
	logic [31:0] price_q;
	logic [31:0] orig_q;
	logic [31:0] rest_q;
	logic        status_q;

	lob_pkg::lvl_cmd_t ask_cmd, bid_cmd;
	logic [31:0] ask_p, ask_qt, bid_p, bid_qt;
	logic        ask_v, bid_v, ask_drop, bid_drop;
	logic [31:0] opp_p, opp_qt;
	logic        opp_v, crosses, take_all, buy;

	assign buy      = (side_q == lob_pkg::SIDE_BID);
	assign opp_p    = buy ? ask_p  : bid_p;
	assign opp_qt   = buy ? ask_qt : bid_qt;
	assign opp_v    = buy ? ask_v  : bid_v;
	assign crosses  = buy ? (opp_p <= price_q) : (opp_p >= price_q);
	assign take_all = (rest_q >= opp_qt);
	assign stat.can_match = (rest_q != 32'd0) && opp_v && crosses;

	// route table commands
	always_comb begin
		ask_cmd       = '0;
		bid_cmd       = '0;
		ask_cmd.price = price_q;
		bid_cmd.price = price_q;
		ask_cmd.qty   = rest_q;
		bid_cmd.qty   = rest_q;
		if (buy) begin
			ask_cmd.pop = cmd.match && take_all;
			ask_cmd.dec = cmd.match && !take_all;
			bid_cmd.set = cmd.set;
		end else begin
			bid_cmd.pop = cmd.match && take_all;
			bid_cmd.dec = cmd.match && !take_all;
			ask_cmd.set = cmd.set;
		end
	end

	lob_levels #(.DEPTH(DEPTH), .ASC(1'b1)) u_ask (
		.clk(clk), .arst_n(arst_n), .cmd(ask_cmd),
		.head_price(ask_p), .head_qty(ask_qt), .head_valid(ask_v), .drop(ask_drop)
	);

	lob_levels #(.DEPTH(DEPTH), .ASC(1'b0)) u_bid (
		.clk(clk), .arst_n(arst_n), .cmd(bid_cmd),
		.head_price(bid_p), .head_qty(bid_qt), .head_valid(bid_v), .drop(bid_drop)
	);

	// load quote, reduce remainder, capture drop flag
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			side_q  <= quote.side;
			price_q <= quote.limit_price;
			orig_q  <= quote.quantity;
			rest_q  <= quote.quantity;
		end else if (cmd.match) begin
			rest_q <= take_all ? (rest_q - opp_qt) : 32'd0;
		end
		if (cmd.set) begin
			status_q <= buy ? bid_drop : ask_drop;
		end
	end

	assign result.filled_qty     = orig_q - rest_q;
	assign result.rest_qty       = rest_q;
	assign result.status         = status_q;
	assign result.best_bid_price = bid_v ? bid_p : 32'd0;
	assign result.best_bid_valid = bid_v;
	assign result.best_ask_price = ask_v ? ask_p : 32'd0;
	assign result.best_ask_valid = ask_v;

endmodule
`default_nettype wire

/* src/lob_ctrl.sv */
// ----------------------------------------------------------------------------
// lob_ctrl
// Controller: match crossing levels one per cycle, set own level, emit.
// ----------------------------------------------------------------------------
`default_nettype none
module lob_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire lob_pkg::dp_stat_t stat,
	output lob_pkg::ctrl_cmd_t     cmd,
	output logic                   busy,
	output logic                   done
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MATCH = 2'd1;
	localparam logic [1:0] ST_SET   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q, state_d;

	assign busy = (state_q == ST_MATCH) || (state_q == ST_SET);
	assign done = (state_q == ST_EMIT);

	// decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_EMIT: begin
				cmd.emit = (state_q == ST_EMIT);
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MATCH;
				end else begin
					state_d  = ST_IDLE;
				end
			end
			ST_MATCH: begin
				if (stat.can_match) begin
					cmd.match = 1'b1;
				end else begin
					state_d = ST_SET;
				end
			end
			ST_SET: begin
				cmd.set = 1'b1;
				state_d = ST_EMIT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_after_set: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_SET) else $error("emit without set");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy) else $error("load while busy");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.match && cmd.set)) else $error("match and set together");

endmodule
`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Quote-matching check of the price-level book core: a scoreboard keeps its
// own bid and ask tables, predicts each result and checks the done strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

class book_scoreboard;
	localparam int DEPTH = 32;
	logic [31:0] ask_px[DEPTH];
	logic [31:0] ask_qt[DEPTH];
	int unsigned ask_n;
	logic [31:0] bid_px[DEPTH];
	logic [31:0] bid_qt[DEPTH];
	int unsigned bid_n;
	lob_pkg::result_t pending_results[$];
	int unsigned error_count;

	function new();
		ask_n = 0;
		bid_n = 0;
		error_count = 0;
	endfunction

	// ask table ascending when asc, bid table descending
	function automatic bit better(logic [31:0] a, logic [31:0] b, bit asc);
		return asc ? (a < b) : (a > b);
	endfunction

	function automatic void drop_at(bit asc, int unsigned idx);
		int unsigned n;
		n = asc ? ask_n : bid_n;
		if (idx >= n) return;
		for (int unsigned i = idx; i + 1 < n; i++) begin
			if (asc) begin
				ask_px[i] = ask_px[i+1];
				ask_qt[i] = ask_qt[i+1];
			end else begin
				bid_px[i] = bid_px[i+1];
				bid_qt[i] = bid_qt[i+1];
			end
		end
		if (asc) ask_n--; else bid_n--;
	endfunction

	// consume crossing levels of the table chosen by asc
	function automatic logic [31:0] consume(bit asc, logic [31:0] lim, logic [31:0] qty);
		logic [31:0] px;
		logic [31:0] q0;
		while (qty != 0 && (asc ? ask_n : bid_n) != 0) begin
			px = asc ? ask_px[0] : bid_px[0];
			q0 = asc ? ask_qt[0] : bid_qt[0];
			if (asc ? (px > lim) : (px < lim)) break;
			if (qty >= q0) begin
				qty -= q0;
				drop_at(asc, 0);
			end else begin
				if (asc) ask_qt[0] = q0 - qty; else bid_qt[0] = q0 - qty;
				qty = 0;
			end
		end
		return qty;
	endfunction

	// set or remove the level at price; return 1 when dropped for lack of room
	function automatic logic place(bit asc, logic [31:0] price, logic [31:0] qty);
		int unsigned n;
		int unsigned pos;
		n = asc ? ask_n : bid_n;
		pos = 0;
		while (pos < n && better(asc ? ask_px[pos] : bid_px[pos], price, asc)) pos++;
		if (pos < n && (asc ? ask_px[pos] : bid_px[pos]) == price) begin
			if (qty == 0) drop_at(asc, pos);
			else if (asc) ask_qt[pos] = qty;
			else bid_qt[pos] = qty;
			return 1'b0;
		end
		if (qty == 0) return 1'b0;
		if (n >= DEPTH) begin
			if (pos >= n) return 1'b1;
			n = DEPTH - 1;
		end
		for (int unsigned i = n; i > pos; i--) begin
			if (asc) begin
				ask_px[i] = ask_px[i-1];
				ask_qt[i] = ask_qt[i-1];
			end else begin
				bid_px[i] = bid_px[i-1];
				bid_qt[i] = bid_qt[i-1];
			end
		end
		if (asc) begin
			ask_px[pos] = price;
			ask_qt[pos] = qty;
			ask_n = n + 1;
		end else begin
			bid_px[pos] = price;
			bid_qt[pos] = qty;
			bid_n = n + 1;
		end
		return 1'b0;
	endfunction

	function automatic void note_quote(lob_pkg::quote_t q);
		lob_pkg::result_t r;
		logic [31:0] rest;
		bit ask_side;
		ask_side = (q.side == lob_pkg::SIDE_ASK);
		rest = consume(!ask_side, q.limit_price, q.quantity);
		r.status = place(ask_side, q.limit_price, rest);
		r.filled_qty = q.quantity - rest;
		r.rest_qty = rest;
		r.best_bid_valid = (bid_n != 0);
		r.best_bid_price = (bid_n != 0) ? bid_px[0] : 32'd0;
		r.best_ask_valid = (ask_n != 0);
		r.best_ask_price = (ask_n != 0) ? ask_px[0] : 32'd0;
		pending_results = {pending_results, r};
	endfunction

	function automatic void check_result(lob_pkg::result_t got);
		lob_pkg::result_t exp;
		if (pending_results.size() == 0) begin
			$error("result with no quote pending");
			error_count++;
			return;
		end
		exp = pending_results.pop_front();
		if (got.filled_qty !== exp.filled_qty) begin
			$error("filled_qty exp %0d got %0d", exp.filled_qty, got.filled_qty);
			error_count++;
		end
		if (got.rest_qty !== exp.rest_qty) begin
			$error("rest_qty exp %0d got %0d", exp.rest_qty, got.rest_qty);
			error_count++;
		end
		if (got.status !== exp.status) begin
			$error("status exp %0d got %0d", exp.status, got.status);
			error_count++;
		end
		if (got.best_bid_price !== exp.best_bid_price) begin
			$error("best_bid_price exp %0d got %0d", exp.best_bid_price, got.best_bid_price);
			error_count++;
		end
		if (got.best_bid_valid !== exp.best_bid_valid) begin
			$error("best_bid_valid exp %0d got %0d", exp.best_bid_valid, got.best_bid_valid);
			error_count++;
		end
		if (got.best_ask_price !== exp.best_ask_price) begin
			$error("best_ask_price exp %0d got %0d", exp.best_ask_price, got.best_ask_price);
			error_count++;
		end
		if (got.best_ask_valid !== exp.best_ask_valid) begin
			$error("best_ask_valid exp %0d got %0d", exp.best_ask_valid, got.best_ask_valid);
			error_count++;
		end
	endfunction
endclass

module tb;

	localparam int WATCHDOG_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic start;
	lob_pkg::quote_t quote;
	logic busy;
	logic done;
	lob_pkg::result_t result;

	book_scoreboard book;
	int unsigned stall_cycles;
	bit gaps_on;

	limit_order_book_level_update_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.quote(quote),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// check each done strobe; count cycles with nothing accepted or done
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) book.check_result(result);
			if ((start && !busy) || done) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// drive one quote and hold start until it is accepted
	task automatic send_quote(logic sd, logic [31:0] px, logic [31:0] qty);
		if (gaps_on) begin
			while ($urandom_range(99) < 25) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start <= 1'b1;
		quote <= '{side: sd, limit_price: px, quantity: qty};
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		book.note_quote(quote);
		@(negedge clk);
	endtask

	// price near a center so the two sides often cross
	function automatic logic [31:0] near_price(logic [31:0] center);
		return center - 32'd40 + $urandom_range(80);
	endfunction

	initial begin
		int unsigned kind;
		logic [31:0] center;
		book = new();
		stall_cycles = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		quote = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty book, extremes, zero quantity, crossing, exact level
		send_quote(lob_pkg::SIDE_BID, 32'd100, 32'd0);
		send_quote(lob_pkg::SIDE_BID, 32'd100, 32'd50);
		send_quote(lob_pkg::SIDE_BID, 32'd100, 32'd70);
		send_quote(lob_pkg::SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_quote(lob_pkg::SIDE_ASK, 32'd0, 32'hFFFF_FFFF);
		send_quote(lob_pkg::SIDE_ASK, 32'd0, 32'hFFFF_FFFF);
		send_quote(lob_pkg::SIDE_BID, 32'd0, 32'hFFFF_FFFF);
		send_quote(lob_pkg::SIDE_ASK, 32'd200, 32'd30);
		send_quote(lob_pkg::SIDE_ASK, 32'd210, 32'd30);
		send_quote(lob_pkg::SIDE_BID, 32'd205, 32'd10);
		send_quote(lob_pkg::SIDE_BID, 32'd220, 32'd100);
		send_quote(lob_pkg::SIDE_ASK, 32'd150, 32'd0);
		send_quote(lob_pkg::SIDE_BID, 32'd220, 32'd0);
		send_quote(lob_pkg::SIDE_BID, 32'd999, 32'd0);
		send_quote(lob_pkg::SIDE_ASK, 32'hAAAA_AAAA, 32'h5555_5555);
		send_quote(lob_pkg::SIDE_BID, 32'h5555_5555, 32'hAAAA_AAAA);
		// fill the bid table past its depth: worse price dropped, better evicts
		for (int i = 0; i < 34; i++)
			send_quote(lob_pkg::SIDE_BID, 32'd1000 + i, 32'd5 + i);
		send_quote(lob_pkg::SIDE_BID, 32'd900, 32'd7);
		send_quote(lob_pkg::SIDE_ASK, 32'd5000, 32'd1);

		// random: mostly crossing quotes near a wandering center
		center = 32'd100000;
		for (int i = 0; i < 600; i++) begin
			gaps_on = !(i >= 200 && i < 320);
			kind = $urandom_range(99);
			if (kind < 5) center = $urandom;
			if (kind < 10)
				send_quote(1'($urandom_range(1)), $urandom, $urandom);
			else if (kind < 20)
				send_quote(1'($urandom_range(1)), near_price(center), 32'd0);
			else
				send_quote(1'($urandom_range(1)), near_price(center),
					$urandom_range(1, 500));
		end
		start <= 1'b0;

		// drain
		while (book.pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (book.error_count == 0 && book.pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

`default_nettype wire
